// ===== design/c2s_pkg.sv =====
// shared constants, angle table and helpers for the cartesian to spherical core
`timescale 1ns / 1ps

package c2s_pkg;

	// input coordinate and angle widths
	localparam int COORD_W = 32;
	localparam int ANG_W = 32;
	localparam int GUARD_W = 8;

	// working width of the cordic datapath (guard bits plus growth headroom)
	localparam int XY_W = 44;

	// cordic iteration limits
	localparam int TABLE_LEN = 40;
	localparam int C2S_STEPS_DEF = 32;

	// gain correction: K = GAIN_Q32 / 2^32
	localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;
	localparam int GAIN_IN_W = 42;
	localparam int LO_W = 16;
	localparam int HI_W = GAIN_IN_W - LO_W;
	localparam int HI_P_W = HI_W + 32;
	localparam int LO_P_W = LO_W + 32;
	localparam int SUM_W = HI_P_W + 1;
	localparam int GF_W = SUM_W - 16;

	// latitude clamp bound and longitude start after a half turn
	localparam logic signed [ANG_W-1:0] LAT_MAX = 32'sh4000_0000;
	localparam logic signed [ANG_W-1:0] LAT_MIN = -32'sh4000_0000;
	localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

	// atan(2^-i) in binary angle units, 2^31 = pi
	localparam logic [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
	};

	// table lookup, zero past the end
	function automatic logic [ANG_W-1:0] atan_entry(input int idx);
		logic [ANG_W-1:0] r;
		r = '0;
		if (idx >= 0 && idx < TABLE_LEN) begin
			r = ATAN_TAB[idx];
		end
		return r;
	endfunction

	// number of iterations actually run
	function automatic int eff_steps(input int steps);
		int r;
		r = (steps < TABLE_LEN) ? steps : TABLE_LEN;
		return r;
	endfunction

endpackage

// ===== design/c2s_cordic_stage.sv =====
// one registered cordic vectoring iteration with a fixed shift
`timescale 1ns / 1ps

module c2s_cordic_stage
	import c2s_pkg::*;
#(
	parameter int SHIFT = 0,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [XY_W-1:0]   in_x,
	input  logic signed [XY_W-1:0]   in_y,
	input  logic [ANG_W-1:0]         in_ang,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic signed [XY_W-1:0]   out_x,
	output logic signed [XY_W-1:0]   out_y,
	output logic [ANG_W-1:0]         out_ang,
	output logic [SIDE_W-1:0]        out_side
);

	localparam logic [ANG_W-1:0] STEP_ANG = atan_entry(SHIFT);

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [XY_W-1:0] nx;
	logic signed [XY_W-1:0] ny;
	logic [ANG_W-1:0] nang;

	logic valid_s1;
	logic signed [XY_W-1:0] x_s1;
	logic signed [XY_W-1:0] y_s1;
	logic [ANG_W-1:0] ang_s1;
	logic [SIDE_W-1:0] side_s1;

	// rotate toward the x axis, direction from the sign of y
	always_comb begin
		dx = in_y >>> SHIFT;
		dy = in_x >>> SHIFT;
		if (!in_y[XY_W-1]) begin
			nx = in_x + dx;
			ny = in_y - dy;
			nang = in_ang + STEP_ANG;
		end else begin
			nx = in_x - dx;
			ny = in_y + dy;
			nang = in_ang - STEP_ANG;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= nx;
			y_s1 <= ny;
			ang_s1 <= nang;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_x = x_s1;
	assign out_y = y_s1;
	assign out_ang = ang_s1;
	assign out_side = side_s1;

endmodule

// ===== design/c2s_cordic_pass.sv =====
// unrolled cordic vectoring pass, one register stage per iteration
`timescale 1ns / 1ps

module c2s_cordic_pass
	import c2s_pkg::*;
#(
	parameter int CORDIC_STEPS = C2S_STEPS_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [XY_W-1:0]   in_x,
	input  logic signed [XY_W-1:0]   in_y,
	input  logic [ANG_W-1:0]         in_ang,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic signed [XY_W-1:0]   out_x,
	output logic [ANG_W-1:0]         out_ang,
	output logic [SIDE_W-1:0]        out_side
);

	localparam int NS = eff_steps(CORDIC_STEPS);

	logic                   v_w [NS+1];
	logic signed [XY_W-1:0] x_w [NS+1];
	logic signed [XY_W-1:0] y_w [NS+1];
	logic [ANG_W-1:0]       a_w [NS+1];
	logic [SIDE_W-1:0]      s_w [NS+1];

	assign v_w[0] = in_valid;
	assign x_w[0] = in_x;
	assign y_w[0] = in_y;
	assign a_w[0] = in_ang;
	assign s_w[0] = in_side;

	// chain of iteration stages
	for (genvar k = 0; k < NS; k++) begin : g_step
		c2s_cordic_stage #(
			.SHIFT (k),
			.SIDE_W(SIDE_W)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_w[k]),
			.in_x     (x_w[k]),
			.in_y     (y_w[k]),
			.in_ang   (a_w[k]),
			.in_side  (s_w[k]),
			.out_valid(v_w[k+1]),
			.out_x    (x_w[k+1]),
			.out_y    (y_w[k+1]),
			.out_ang  (a_w[k+1]),
			.out_side (s_w[k+1])
		);
	end

	assign out_valid = v_w[NS];
	assign out_x = x_w[NS];
	assign out_ang = a_w[NS];
	assign out_side = s_w[NS];

endmodule

// ===== design/c2s_gain.sv =====
// two-stage cordic gain correction, multiply by K with round half up
`timescale 1ns / 1ps

module c2s_gain
	import c2s_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [XY_W-1:0]   in_v,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic [GF_W-1:0]          out_res,
	output logic [SIDE_W-1:0]        out_side
);

	logic [GAIN_IN_W-1:0] u;
	logic [LO_P_W:0] lo_rnd;
	logic [SUM_W-1:0] sum;

	logic valid_s1;
	logic valid_s2;
	logic [HI_P_W-1:0] hi_p_s1;
	logic [LO_P_W-1:0] lo_p_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [GF_W-1:0] res_s2;
	logic [SIDE_W-1:0] side_s2;

	// negative values clamp to zero
	assign u = (in_v > 0) ? in_v[GAIN_IN_W-1:0] : '0;

	// combine partial products
	always_comb begin
		lo_rnd = (LO_P_W+1)'(lo_p_s1) + (LO_P_W+1)'(33'h0_8000_0000);
		sum = SUM_W'(hi_p_s1) + SUM_W'(lo_rnd >> 16);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// split multiply, then sum and drop the fraction
	always_ff @(posedge clk) begin
		if (en) begin
			hi_p_s1 <= HI_P_W'(u[GAIN_IN_W-1:LO_W]) * HI_P_W'(GAIN_Q32);
			lo_p_s1 <= LO_P_W'(u[LO_W-1:0]) * LO_P_W'(GAIN_Q32);
			side_s1 <= in_side;
			res_s2 <= sum[SUM_W-1:16];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_res = res_s2;
	assign out_side = side_s2;

endmodule

// ===== design/cartesian_to_spherical_core.sv =====
// throughput: one request per cycle while the skid entry is free; each cordic iteration has its
// own register stage, and the gain multiply has a partial product stage and a sum stage,
// so every unit is busy once per cycle
// a two-entry output stage keeps taking requests while one result waits
// reset clears all valid bits asynchronously; payload registers are not reset
`timescale 1ns / 1ps

module cartesian_to_spherical_core
	import c2s_pkg::*;
#(
	parameter int CORDIC_STEPS = C2S_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // longitude [31:0], latitude [63:32], radius [95:64]
);

	localparam int S1_W = COORD_W + 1;
	localparam int G_W = S1_W + ANG_W;

	logic en;

	// input preparation
	logic signed [COORD_W-1:0] cx;
	logic signed [COORD_W-1:0] cy;
	logic signed [COORD_W-1:0] cz;
	logic signed [XY_W-1:0] xe;
	logic signed [XY_W-1:0] ye;
	logic prep_valid_s1;
	logic signed [XY_W-1:0] prep_x_s1;
	logic signed [XY_W-1:0] prep_y_s1;
	logic [ANG_W-1:0] prep_ang_s1;
	logic [S1_W-1:0] prep_side_s1;

	// pass one and its gain
	logic p1_valid;
	logic signed [XY_W-1:0] p1_x;
	logic [ANG_W-1:0] p1_ang;
	logic [S1_W-1:0] p1_side;
	logic g1_valid;
	logic [GF_W-1:0] g1_res;
	logic [G_W-1:0] g1_side;

	// pass two entry
	logic signed [COORD_W-1:0] z1;
	logic zxy;
	logic [ANG_W-1:0] lon_eff;
	logic [GF_W-1:0] rho;
	logic zero2;
	logic signed [XY_W-1:0] x2;
	logic signed [XY_W-1:0] y2;

	// pass two and its gain
	logic p2_valid;
	logic signed [XY_W-1:0] p2_x;
	logic [ANG_W-1:0] p2_ang;
	logic [S1_W-1:0] p2_side;
	logic g2_valid;
	logic [GF_W-1:0] g2_res;
	logic [G_W-1:0] g2_side;

	// final rounding and clamps
	logic signed [ANG_W-1:0] lat_raw;
	logic [ANG_W-1:0] lat;
	logic [ANG_W-1:0] lon;
	logic [GF_W:0] rad_sum;
	logic [GF_W-8:0] rad_sh;
	logic [COORD_W-1:0] rad;
	logic fin_valid;
	logic [95:0] fin_data;

	// output and skid registers
	logic out_valid_q;
	logic [95:0] out_data_q;
	logic skid_valid_q;
	logic [95:0] skid_data_q;

	// pipeline moves whenever the skid entry is free
	assign en = !skid_valid_q;
	assign s_tready = en;

	// unpack and scale by the guard bits
	always_comb begin
		cx = s_tdata[31:0];
		cy = s_tdata[63:32];
		cz = s_tdata[95:64];
		xe = {{(XY_W-COORD_W-GUARD_W){cx[COORD_W-1]}}, cx, {GUARD_W{1'b0}}};
		ye = {{(XY_W-COORD_W-GUARD_W){cy[COORD_W-1]}}, cy, {GUARD_W{1'b0}}};
	end

	// turn left half-plane points by pi before pass one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_valid_s1 <= 1'b0;
		end else if (en) begin
			prep_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (xe < 0) begin
				prep_x_s1 <= -xe;
				prep_y_s1 <= -ye;
				prep_ang_s1 <= HALF_TURN;
			end else begin
				prep_x_s1 <= xe;
				prep_y_s1 <= ye;
				prep_ang_s1 <= '0;
			end
			prep_side_s1 <= {(cx == 0) && (cy == 0), cz};
		end
	end

	// longitude pass
	c2s_cordic_pass #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.SIDE_W      (S1_W)
	) u_pass1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (prep_valid_s1),
		.in_x     (prep_x_s1),
		.in_y     (prep_y_s1),
		.in_ang   (prep_ang_s1),
		.in_side  (prep_side_s1),
		.out_valid(p1_valid),
		.out_x    (p1_x),
		.out_ang  (p1_ang),
		.out_side (p1_side)
	);

	c2s_gain #(
		.SIDE_W(G_W)
	) u_gain1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (p1_valid),
		.in_v     (p1_x),
		.in_side  ({p1_ang, p1_side}),
		.out_valid(g1_valid),
		.out_res  (g1_res),
		.out_side (g1_side)
	);

	// rho and z feed the latitude pass; zero cases are flagged here
	always_comb begin
		z1 = g1_side[COORD_W-1:0];
		zxy = g1_side[COORD_W];
		lon_eff = zxy ? '0 : g1_side[G_W-1:S1_W];
		rho = zxy ? '0 : g1_res;
		zero2 = (rho == '0) && (z1 == 0);
		x2 = XY_W'(rho);
		y2 = {{(XY_W-COORD_W-GUARD_W){z1[COORD_W-1]}}, z1, {GUARD_W{1'b0}}};
	end

	// latitude pass
	c2s_cordic_pass #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.SIDE_W      (S1_W)
	) u_pass2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (g1_valid),
		.in_x     (x2),
		.in_y     (y2),
		.in_ang   ('0),
		.in_side  ({zero2, lon_eff}),
		.out_valid(p2_valid),
		.out_x    (p2_x),
		.out_ang  (p2_ang),
		.out_side (p2_side)
	);

	c2s_gain #(
		.SIDE_W(G_W)
	) u_gain2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (p2_valid),
		.in_v     (p2_x),
		.in_side  ({p2_ang, p2_side}),
		.out_valid(g2_valid),
		.out_res  (g2_res),
		.out_side (g2_side)
	);

	// clamp latitude, round and saturate radius, and zero both at the origin
	always_comb begin
		lon = g2_side[ANG_W-1:0];
		lat_raw = g2_side[G_W-1:S1_W];
		if (lat_raw > LAT_MAX) begin
			lat = LAT_MAX;
		end else if (lat_raw < LAT_MIN) begin
			lat = LAT_MIN;
		end else begin
			lat = lat_raw;
		end
		rad_sum = (GF_W+1)'(g2_res) + (GF_W+1)'(1 << (GUARD_W - 1));
		rad_sh = rad_sum[GF_W:GUARD_W];
		rad = (|rad_sh[GF_W-8:COORD_W]) ? '1 : rad_sh[COORD_W-1:0];
		if (g2_side[ANG_W]) begin
			lat = '0;
			rad = '0;
		end
		fin_valid = en && g2_valid;
		fin_data = {rad, lat, lon};
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= fin_valid;
			end
		end else if (fin_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= fin_data;
			end
		end else if (fin_valid) begin
			skid_data_q <= fin_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule
